@@ hw/rtl/gdc_pkg.sv @@
package gdc_pkg;

  localparam int MAX_YEAR   = 9999;
  localparam int DAYS_YEAR  = 365;
  localparam int DAYS_4Y    = 1461;
  localparam int DAYS_100Y  = 36524;
  localparam int DAYS_400Y  = 146097;

  // last valid day number: day number of MAX_YEAR-12-31
  localparam int KMAX_INT = MAX_YEAR * DAYS_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                            + MAX_YEAR / 400;
  localparam logic [21:0] KMAX = 22'(KMAX_INT);

  // register stages inside each converter
  localparam int LAT = 7;

  localparam logic OP_TO_DAYS = 1'b0;
  localparam logic OP_TO_DATE = 1'b1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [21:0] day_number;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic        error;
  } gdc_result_t;

  // days in month, common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days of a common year before the first of month m
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // 8 == 1 mod 7, so fold octal digits
  function automatic logic [2:0] mod7(input logic [21:0] k);
    logic [23:0] kk;
    logic [5:0]  s1;
    logic [3:0]  s2;
    kk = {2'b00, k};
    s1 = 6'd0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(kk[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      return 3'(s2 - 4'd7);
    end
    return s2[2:0];
  endfunction

endpackage

@@ hw/rtl/gdc_to_days.sv @@
module gdc_to_days import gdc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [13:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  output gdc_result_t res
);

  // stage 1
  logic [13:0] s1_y;
  logic [3:0]  s1_m;
  logic [4:0]  s1_d;
  logic [13:0] s1_p;
  logic [22:0] s1_p365;
  logic [7:0]  s1_qp;
  logic        s1_bad;

  // stage 2
  logic [13:0] s2_y;
  logic [3:0]  s2_m;
  logic [4:0]  s2_d;
  logic [22:0] s2_base;
  logic [7:0]  s2_qq;
  logic        s2_leap;
  logic        s2_bad;

  // stage 3
  logic [13:0] s3_y;
  logic [3:0]  s3_m;
  logic [4:0]  s3_d;
  logic [21:0] s3_k;
  logic        s3_bad;

  gdc_result_t res_pipe [LAT-3];

  logic [13:0] p_c;
  logic [26:0] qp_prod;
  logic [13:0] rem_c;
  logic        leap_c;
  logic [4:0]  len_c;
  logic [22:0] k_c;

  always_comb begin
    p_c     = year_in - 14'd1;
    // p / 100 by reciprocal, exact for 14-bit p
    qp_prod = 27'(p_c) * 27'(5243);
    rem_c   = s1_p - 14'(s1_qp) * 14'd100;
    leap_c  = (s1_p[1:0] == 2'd3) && ((rem_c != 14'd99) || (s1_qp[1:0] == 2'd3));
    len_c   = month_len(s1_m) + 5'((s1_m == MONTH_FEB) && leap_c);
    k_c     = s2_base - 23'(s2_qq) + 23'(month_start(s2_m))
              + 23'(s2_leap && (s2_m > MONTH_FEB)) + 23'(s2_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_y    <= year_in;
      s1_m    <= month_in;
      s1_d    <= day_in;
      s1_p    <= p_c;
      s1_p365 <= 23'(p_c) * 23'(DAYS_YEAR);
      s1_qp   <= qp_prod[26:19];
      s1_bad  <= (year_in == 14'd0) || (year_in > 14'(MAX_YEAR)) ||
                 (month_in < MONTH_JAN) || (month_in > MONTH_DEC) || (day_in == 5'd0);

      s2_y    <= s1_y;
      s2_m    <= s1_m;
      s2_d    <= s1_d;
      s2_base <= s1_p365 + 23'(s1_p[13:2]);
      // p/100 - p/400, subtracted from the base
      s2_qq   <= s1_qp - {2'b00, s1_qp[7:2]};
      s2_leap <= leap_c;
      s2_bad  <= s1_bad || (s1_d > len_c);

      s3_y    <= s2_y;
      s3_m    <= s2_m;
      s3_d    <= s2_d;
      s3_k    <= k_c[21:0];
      s3_bad  <= s2_bad;

      res_pipe[0].day_number <= s3_k;
      res_pipe[0].year       <= s3_y;
      res_pipe[0].month      <= s3_m;
      res_pipe[0].day        <= s3_d;
      res_pipe[0].weekday    <= mod7(s3_k);
      res_pipe[0].error      <= s3_bad;
      for (int i = 1; i < LAT - 3; i++) begin
        res_pipe[i] <= res_pipe[i-1];
      end
    end
  end

  assign res = res_pipe[LAT-4];

endmodule

@@ hw/rtl/gdc_to_date.sv @@
module gdc_to_date import gdc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [21:0] day_number_in,
  output gdc_result_t res
);

  // values carried along every stage
  logic [21:0] k_pipe   [LAT];
  logic [2:0]  wd_pipe  [LAT];
  logic        bad_pipe [LAT];

  // stage 1
  logic [21:0] s1_n;
  logic [4:0]  s1_qe;
  // stage 2
  logic [4:0]  s2_q400;
  logic [17:0] s2_r;
  // stage 3
  logic [4:0]  s3_q400;
  logic [1:0]  s3_c;
  logic [15:0] s3_r2;
  // stage 4
  logic [4:0]  s4_q400;
  logic [1:0]  s4_c;
  logic [15:0] s4_r2;
  logic [4:0]  s4_q4;
  // stage 5
  logic [4:0]  s5_q400;
  logic [1:0]  s5_c;
  logic [4:0]  s5_q4;
  logic [10:0] s5_r3;
  // stage 6
  logic [13:0] s6_year;
  logic [8:0]  s6_r4;
  logic        s6_leap;
  // stage 7
  logic [13:0] s7_year;
  logic [3:0]  s7_month;
  logic [4:0]  s7_day;

  logic [21:0] n_c;
  logic [31:0] qe_prod;
  logic [22:0] r0_c;
  logic [1:0]  c_c;
  logic [15:0] c_off;
  logic [30:0] q4_prod;
  logic [1:0]  y1_c;
  logic [10:0] y1_off;
  logic [8:0]  thr;
  logic [3:0]  m_c;
  logic [8:0]  start_c;

  always_comb begin
    n_c     = day_number_in - 22'd1;
    // under-estimate of n / 146097, off by at most one
    qe_prod = 32'(n_c) * 32'(918);
    r0_c    = 23'(s1_n) - 23'(s1_qe) * 23'(DAYS_400Y);

    c_c = 2'(r0_c[17:0] >= 18'(DAYS_100Y)) ;
    c_c = 2'((s2_r >= 18'(DAYS_100Y))) + 2'((s2_r >= 18'(2 * DAYS_100Y)))
          + 2'((s2_r >= 18'(3 * DAYS_100Y)));
    case (c_c)
      2'd1:    c_off = 16'(DAYS_100Y);
      2'd2:    c_off = 16'(2 * DAYS_100Y);
      2'd3:    c_off = 16'(3 * DAYS_100Y);
      default: c_off = 16'd0;
    endcase

    // r2 / 1461 by reciprocal, exact below 36525
    q4_prod = 31'(s3_r2) * 31'(22967);

    y1_c = 2'((s5_r3 >= 11'(DAYS_YEAR))) + 2'((s5_r3 >= 11'(2 * DAYS_YEAR)))
           + 2'((s5_r3 >= 11'(3 * DAYS_YEAR)));
    case (y1_c)
      2'd1:    y1_off = 11'(DAYS_YEAR);
      2'd2:    y1_off = 11'(2 * DAYS_YEAR);
      2'd3:    y1_off = 11'(3 * DAYS_YEAR);
      default: y1_off = 11'd0;
    endcase

    // thresholds rise with the month, keep the last one reached
    m_c = MONTH_JAN;
    thr = 9'd0;
    for (int i = 2; i <= 12; i++) begin
      thr = month_start(4'(i)) + 9'(s6_leap && (i > 2));
      if (s6_r4 >= thr) begin
        m_c = 4'(i);
      end
    end
    start_c = month_start(m_c) + 9'(s6_leap && (m_c > MONTH_FEB));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_pipe[0]   <= day_number_in;
      wd_pipe[0]  <= mod7(day_number_in);
      bad_pipe[0] <= (day_number_in == 22'd0) || (day_number_in > KMAX);
      for (int i = 1; i < LAT; i++) begin
        k_pipe[i]   <= k_pipe[i-1];
        wd_pipe[i]  <= wd_pipe[i-1];
        bad_pipe[i] <= bad_pipe[i-1];
      end

      s1_n  <= n_c;
      s1_qe <= qe_prod[31:27];

      if (r0_c >= 23'(DAYS_400Y)) begin
        s2_q400 <= s1_qe + 5'd1;
        s2_r    <= 18'(r0_c - 23'(DAYS_400Y));
      end else begin
        s2_q400 <= s1_qe;
        s2_r    <= r0_c[17:0];
      end

      s3_q400 <= s2_q400;
      s3_c    <= c_c;
      s3_r2   <= 16'(s2_r - 18'(c_off));

      s4_q400 <= s3_q400;
      s4_c    <= s3_c;
      s4_r2   <= s3_r2;
      s4_q4   <= q4_prod[29:25];

      s5_q400 <= s4_q400;
      s5_c    <= s4_c;
      s5_q4   <= s4_q4;
      s5_r3   <= 11'(s4_r2 - 16'(s4_q4) * 16'(DAYS_4Y));

      s6_year <= 14'(s5_q400) * 14'd400 + 14'(s5_c) * 14'd100 + 14'({s5_q4, 2'b00})
                 + 14'(y1_c) + 14'd1;
      s6_r4   <= 9'(s5_r3 - y1_off);
      s6_leap <= (y1_c == 2'd3) && ((s5_q4 != 5'd24) || (s5_c == 2'd3));

      s7_year  <= s6_year;
      s7_month <= m_c;
      s7_day   <= 5'(s6_r4 - start_c + 9'd1);
    end
  end

  always_comb begin
    res.day_number = k_pipe[LAT-1];
    res.year       = s7_year;
    res.month      = s7_month;
    res.day        = s7_day;
    res.weekday    = wd_pipe[LAT-1];
    res.error      = bad_pipe[LAT-1];
  end

endmodule

@@ hw/rtl/gregorian_date_day_number_converter_core.sv @@
// an input transfer passes the 7 converter stages and then the output register on its
// way to out_valid; one item per cycle while the output is not held
// a held output (out_valid with out_stall) freezes the whole pipe and raises in_stall
// reset (rst, synchronous, active high) clears the stage valid bits and out_valid;
// data registers are not reset
module gregorian_date_day_number_converter_core import gdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [13:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [21:0] day_number_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] day_number_out,
  output logic [13:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [2:0]  weekday,
  output logic        error
);

  logic             en;
  logic [LAT-1:0]   vld;
  logic [LAT-1:0]   op_pipe;
  gdc_result_t      res_days;
  gdc_result_t      res_date;
  gdc_result_t      sel;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  gdc_to_days u_to_days (
    .clk      (clk),
    .en       (en),
    .year_in  (year_in),
    .month_in (month_in),
    .day_in   (day_in),
    .res      (res_days)
  );

  gdc_to_date u_to_date (
    .clk           (clk),
    .en            (en),
    .day_number_in (day_number_in),
    .res           (res_date)
  );

  always_comb begin
    sel = (op_pipe[LAT-1] == OP_TO_DATE) ? res_date : res_days;
    if (sel.error) begin
      sel = '0;
      sel.error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[LAT-2:0], in_valid};
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_pipe        <= {op_pipe[LAT-2:0], operation};
      day_number_out <= sel.day_number;
      year_out       <= sel.year;
      month_out      <= sel.month;
      day_out        <= sel.day;
      weekday        <= sel.weekday;
      error          <= sel.error;
    end
  end

`ifndef NO_ASSERTIONS
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> day_number_out == 22'd0 && year_out == 14'd0 &&
      month_out == 4'd0 && day_out == 5'd0 && weekday == 3'd0)
    else $error("error result carries nonzero fields");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> month_out >= MONTH_JAN && month_out <= MONTH_DEC &&
      day_out != 5'd0 && year_out != 14'd0 && year_out <= 14'(MAX_YEAR) &&
      day_number_out != 22'd0 && day_number_out <= KMAX)
    else $error("valid result out of calendar range");

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> weekday == mod7(day_number_out))
    else $error("weekday does not match day number");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(out_valid && out_stall) |-> $stable(vld) && $stable(op_pipe))
    else $error("pipe moved during output stall");
`endif

endmodule
